// ===== rtl/bsmr_pkg.sv =====
package bsmr_pkg;

  localparam int MSG_SLOTS = 64;
  localparam int MSG_BYTES = 1024;
  localparam int CHAR_BITS = 8;

  localparam int SLOT_W = $clog2(MSG_SLOTS);
  localparam int LEN_W  = $clog2(MSG_BYTES);
  localparam int CNT_W  = $clog2(MSG_SLOTS + 1);
  localparam int ADDR_W = SLOT_W + LEN_W;
  localparam int BCNT_W = $clog2(CHAR_BITS);

  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MSG_BYTES - 1);
  localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(MSG_SLOTS);
  localparam logic [LEN_W-1:0] EXIT_LEN = LEN_W'(4);

  localparam logic [7:0] EXIT_WORD [4] = '{8'h65, 8'h78, 8'h69, 8'h74};

  typedef enum logic [2:0] {
    EV_BIT      = 3'd0,
    EV_APPEND   = 3'd1,
    EV_CH_DROP  = 3'd2,
    EV_STORED   = 3'd3,
    EV_MSG_DROP = 3'd4,
    EV_EXIT     = 3'd5,
    EV_READ     = 3'd6
  } ev_t;

  typedef struct packed {
    ev_t              ev;
    logic [7:0]       chr;
    logic [CNT_W-1:0] count;
    logic [LEN_W-1:0] len;
    logic             exit_flag;
  } res_t;

  // write requests from the control unit to the store
  typedef struct packed {
    logic              byte_we;
    logic [ADDR_W-1:0] byte_addr;
    logic [7:0]        byte_data;
    logic              len_we;
    logic [SLOT_W-1:0] len_addr;
    logic [LEN_W-1:0]  len_data;
  } wr_req_t;

endpackage

// ===== rtl/bsmr_store.sv =====
module bsmr_store (
  input  logic                          clk,
  input  bsmr_pkg::wr_req_t             wr,
  input  logic                          rd_en,
  input  logic [bsmr_pkg::SLOT_W-1:0]   rd_slot,
  input  logic [bsmr_pkg::LEN_W-1:0]    rd_off,
  output logic [7:0]                    rd_byte,
  output logic [bsmr_pkg::LEN_W-1:0]    rd_len
);

  logic [7:0]                 byte_mem [bsmr_pkg::MSG_SLOTS * bsmr_pkg::MSG_BYTES];
  logic [bsmr_pkg::LEN_W-1:0] len_mem  [bsmr_pkg::MSG_SLOTS];

  always_ff @(posedge clk) begin
    if (wr.byte_we) begin
      byte_mem[wr.byte_addr] <= wr.byte_data;
    end
    if (wr.len_we) begin
      len_mem[wr.len_addr] <= wr.len_data;
    end
  end

  // read data holds between read requests so a stalled result keeps it
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_byte <= byte_mem[{rd_slot, rd_off}];
      rd_len  <= len_mem[rd_slot];
    end
  end

endmodule

// ===== rtl/bsmr_ctrl.sv =====
module bsmr_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic                         mode,
  input  logic                         bit_value,
  output bsmr_pkg::wr_req_t            wr,
  output bsmr_pkg::res_t               res,
  output logic [bsmr_pkg::CNT_W-1:0]   stored_count
);

  logic [7:0]                  partial_char, partial_char_next;
  logic [bsmr_pkg::BCNT_W-1:0] bit_count, bit_count_next;
  logic [bsmr_pkg::LEN_W-1:0]  current_length, current_length_next;
  logic                        prefix_match, prefix_match_next;
  logic [bsmr_pkg::CNT_W-1:0]  stored_count_next;
  logic                        exit_seen, exit_seen_next;
  logic [7:0]                  assembled;
  logic                        char_done;
  logic                        store_free;

  assign assembled  = partial_char | (8'(bit_value) << bit_count);
  assign char_done  = (bit_count == bsmr_pkg::BCNT_W'(bsmr_pkg::CHAR_BITS - 1));
  assign store_free = (stored_count < bsmr_pkg::SLOTS_C);

  always_comb begin
    partial_char_next   = partial_char;
    bit_count_next      = bit_count;
    current_length_next = current_length;
    prefix_match_next   = prefix_match;
    stored_count_next   = stored_count;
    exit_seen_next      = exit_seen;

    wr.byte_we   = 1'b0;
    wr.byte_addr = {stored_count[bsmr_pkg::SLOT_W-1:0], current_length};
    wr.byte_data = assembled;
    wr.len_we    = 1'b0;
    wr.len_addr  = stored_count[bsmr_pkg::SLOT_W-1:0];
    wr.len_data  = current_length;

    res.ev  = bsmr_pkg::EV_READ;
    res.chr = 8'd0;
    res.len = '0;

    if (accept && !mode) begin
      if (!char_done) begin
        partial_char_next = assembled;
        bit_count_next    = bit_count + 1'b1;
        res.ev            = bsmr_pkg::EV_BIT;
        res.len           = current_length;
      end else begin
        partial_char_next = 8'd0;
        bit_count_next    = '0;
        if (assembled != 8'd0) begin
          res.chr = assembled;
          if (current_length < bsmr_pkg::LEN_MAX) begin
            wr.byte_we = store_free;
            if (current_length >= bsmr_pkg::EXIT_LEN ||
                assembled != bsmr_pkg::EXIT_WORD[current_length[1:0]]) begin
              prefix_match_next = 1'b0;
            end
            current_length_next = current_length + 1'b1;
            res.ev  = bsmr_pkg::EV_APPEND;
            res.len = current_length + 1'b1;
          end else begin
            res.ev  = bsmr_pkg::EV_CH_DROP;
            res.len = current_length;
          end
        end else begin
          // terminator: exit check wins over storing
          priority if (prefix_match && current_length == bsmr_pkg::EXIT_LEN) begin
            exit_seen_next = 1'b1;
            res.ev         = bsmr_pkg::EV_EXIT;
          end else if (store_free) begin
            wr.len_we         = 1'b1;
            stored_count_next = stored_count + 1'b1;
            res.ev            = bsmr_pkg::EV_STORED;
          end else begin
            res.ev = bsmr_pkg::EV_MSG_DROP;
          end
          res.len             = current_length;
          current_length_next = '0;
          prefix_match_next   = 1'b1;
        end
      end
    end

    res.count     = stored_count_next;
    res.exit_flag = exit_seen_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_char   <= 8'd0;
      bit_count      <= '0;
      current_length <= '0;
      prefix_match   <= 1'b1;
      stored_count   <= '0;
      exit_seen      <= 1'b0;
    end else begin
      partial_char   <= partial_char_next;
      bit_count      <= bit_count_next;
      current_length <= current_length_next;
      prefix_match   <= prefix_match_next;
      stored_count   <= stored_count_next;
      exit_seen      <= exit_seen_next;
    end
  end

endmodule

// ===== rtl/bit_serial_message_receiver_top.sv =====
// Each accepted request passes the store's registered read and then the output
//   register. Throughput: one request per cycle unless stalled by m_axis_tready,
//   bits and reads freely interleaved.
// Reset (rst, synchronous): clears the bit assembler, message length, slot
//   count and exit flag; the byte and length stores are not cleared.
module bit_serial_message_receiver_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // bit_value[0], read_slot[6:1], read_offset[16:7]
  input  logic [0:0]  s_axis_tuser,  // mode[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // char_value[7:0], message_count[14:8],
                                     // message_length[24:15], exit_flag[25]
  output logic [2:0]  m_axis_tuser   // event_res[2:0]
);

  logic                        accept;
  logic                        advance;
  logic                        mode;
  logic                        bit_value;
  logic [bsmr_pkg::SLOT_W-1:0] read_slot;
  logic [bsmr_pkg::LEN_W-1:0]  read_offset;

  bsmr_pkg::wr_req_t           wr;
  bsmr_pkg::res_t              res;
  logic [bsmr_pkg::CNT_W-1:0]  stored_count;
  logic [7:0]                  rd_byte;
  logic [bsmr_pkg::LEN_W-1:0]  rd_len;

  logic                        s1_valid;
  bsmr_pkg::res_t              s1_res;
  logic                        s1_slot_ok;
  logic [bsmr_pkg::LEN_W-1:0]  s1_off;
  bsmr_pkg::res_t              fin;
  logic                        out_valid;
  bsmr_pkg::res_t              out_res;

  assign mode        = s_axis_tuser[0];
  assign bit_value   = s_axis_tdata[0];
  assign read_slot   = s_axis_tdata[6:1];
  assign read_offset = s_axis_tdata[16:7];

  assign advance       = s1_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !s1_valid || advance;
  assign accept        = s_axis_tvalid && s_axis_tready;

  bsmr_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .mode         (mode),
    .bit_value    (bit_value),
    .wr           (wr),
    .res          (res),
    .stored_count (stored_count)
  );

  bsmr_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (accept && mode),
    .rd_slot (read_slot),
    .rd_off  (read_offset),
    .rd_byte (rd_byte),
    .rd_len  (rd_len)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res     <= res;
      s1_slot_ok <= ({1'b0, read_slot} < stored_count);
      s1_off     <= read_offset;
    end
    if (advance) begin
      out_res <= fin;
    end
  end

  // read requests: only bytes below the stored length of a filled slot count
  always_comb begin
    fin = s1_res;
    if (s1_res.ev == bsmr_pkg::EV_READ) begin
      fin.len = s1_slot_ok ? rd_len : '0;
      fin.chr = (s1_slot_ok && s1_off < rd_len) ? rd_byte : 8'd0;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_res.ev;
  assign m_axis_tdata  = {6'd0, out_res.exit_flag, out_res.len, out_res.count, out_res.chr};

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stored_count <= bsmr_pkg::SLOTS_C)
    else $error("slot count beyond store size");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    (wr.byte_we || wr.len_we) |-> (stored_count < bsmr_pkg::SLOTS_C))
    else $error("store write with no free slot");

  a_exit_sticky: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.exit_flag && m_axis_tready) |=>
      (!out_valid || out_res.exit_flag))
    else $error("exit flag cleared");

endmodule

// ===== bench/bit_serial_message_receiver_top_test.sv =====
`timescale 1ns / 1ps

module bit_serial_message_receiver_top_test;

  localparam bit MODE_BIT  = 1'b0;
  localparam bit MODE_READ = 1'b1;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 260;

  typedef logic [7:0] byte_q_t[$];
  typedef logic [bsmr_pkg::SLOT_W-1:0] slot_t;
  typedef logic [bsmr_pkg::LEN_W-1:0] offset_t;

  // Tracks the receiver state and holds the results still owed by the block.
  class msg_rx_scoreboard;
    logic [7:0]                 char_acc;
    int unsigned                bits_in;
    logic [bsmr_pkg::LEN_W-1:0] msg_len;
    bit                         exit_prefix_ok;
    logic [bsmr_pkg::CNT_W-1:0] slots_used;
    bit                         exit_latched;
    logic [7:0]                 byte_mem [bsmr_pkg::MSG_SLOTS*bsmr_pkg::MSG_BYTES];
    logic [bsmr_pkg::LEN_W-1:0] len_mem [bsmr_pkg::MSG_SLOTS];
    bsmr_pkg::res_t             results_due[$];
    int                         mismatches;

    function new();
      char_acc = '0;
      bits_in = 0;
      msg_len = '0;
      exit_prefix_ok = 1'b1;
      slots_used = '0;
      exit_latched = 1'b0;
      mismatches = 0;
    endfunction

    function int due_count();
      return results_due.size();
    endfunction

    function void predict_request(bit mode, bit bit_val, slot_t slot, offset_t offset);
      bsmr_pkg::res_t r;
      logic [7:0] c;
      r = '0;
      r.ev = bsmr_pkg::EV_BIT;
      if (mode == MODE_READ) begin
        r.ev = bsmr_pkg::EV_READ;
        if (slot < slots_used) begin
          r.len = len_mem[slot];
          if (offset < r.len)
            r.chr = byte_mem[int'(slot) * bsmr_pkg::MSG_BYTES + int'(offset)];
        end
      end else begin
        // bits arrive LSB first
        if (bit_val) char_acc[bits_in] = 1'b1;
        if (bits_in != bsmr_pkg::CHAR_BITS - 1) begin
          bits_in++;
          r.len = msg_len;
        end else begin
          c = char_acc;
          char_acc = '0;
          bits_in = 0;
          if (c != 8'h00) begin
            r.chr = c;
            if (msg_len < bsmr_pkg::LEN_MAX) begin
              // store full: character counted but not written
              if (slots_used < bsmr_pkg::SLOTS_C)
                byte_mem[int'(slots_used) * bsmr_pkg::MSG_BYTES + int'(msg_len)] = c;
              if (msg_len >= bsmr_pkg::EXIT_LEN || c != bsmr_pkg::EXIT_WORD[msg_len[1:0]])
                exit_prefix_ok = 1'b0;
              msg_len++;
              r.ev = bsmr_pkg::EV_APPEND;
            end else begin
              r.ev = bsmr_pkg::EV_CH_DROP;
            end
            r.len = msg_len;
          end else begin
            r.len = msg_len;
            if (exit_prefix_ok && msg_len == bsmr_pkg::EXIT_LEN) begin
              exit_latched = 1'b1;
              r.ev = bsmr_pkg::EV_EXIT;
            end else if (slots_used < bsmr_pkg::SLOTS_C) begin
              len_mem[slots_used[bsmr_pkg::SLOT_W-1:0]] = msg_len;
              slots_used++;
              r.ev = bsmr_pkg::EV_STORED;
            end else begin
              r.ev = bsmr_pkg::EV_MSG_DROP;
            end
            msg_len = '0;
            exit_prefix_ok = 1'b1;
          end
        end
      end
      r.count = slots_used;
      r.exit_flag = exit_latched;
      results_due.push_back(r);
    endfunction

    function void compare_field(string what, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(bsmr_pkg::res_t got);
      bsmr_pkg::res_t want;
      if (results_due.size() == 0) begin
        $display("%0t ns: result with no request outstanding, expected none, actual event %0d",
                 $time, got.ev);
        mismatches++;
        return;
      end
      want = results_due.pop_front();
      compare_field("event", 16'(want.ev), 16'(got.ev));
      compare_field("char", 16'(want.chr), 16'(got.chr));
      compare_field("message_count", 16'(want.count), 16'(got.count));
      compare_field("message_length", 16'(want.len), 16'(got.len));
      compare_field("exit_flag", 16'(want.exit_flag), 16'(got.exit_flag));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;  // bit_value[0], read_slot[6:1], read_offset[16:7]
  logic [0:0]  s_axis_tuser = '0;  // mode[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;       // char_value[7:0], message_count[14:8],
                                   // message_length[24:15], exit_flag[25]
  logic [2:0]  m_axis_tuser;       // event_res[2:0]

  bit              no_idle = 1'b0;
  int unsigned     items_sent = 0;
  int unsigned     quiet_cycles = 0;
  msg_rx_scoreboard sb = new();

  always #6 clk = ~clk;

  bit_serial_message_receiver_top u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always @(posedge clk) begin
    bsmr_pkg::res_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = '0;
      got.ev = bsmr_pkg::ev_t'(m_axis_tuser);
      got.chr = m_axis_tdata[7:0];
      got.count = m_axis_tdata[14:8];
      got.len = m_axis_tdata[24:15];
      got.exit_flag = m_axis_tdata[25];
      sb.check_result(got);
    end
    m_axis_tready <= no_idle || ($urandom_range(99) >= 36);
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("bit_serial_message_receiver_top test failed");
      $finish;
    end
  end

  // tvalid is only lowered while idling, so back-to-back requests never see two updates
  task automatic send_req(input bit mode, input bit bit_val, input slot_t slot,
                          input offset_t offset);
    while (!no_idle && $urandom_range(99) < 36) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= mode;
    s_axis_tdata <= {7'b0, offset, slot, bit_val};
    do @(posedge clk); while (!s_axis_tready);
    sb.predict_request(mode, bit_val, slot, offset);
    items_sent++;
  endtask

  task automatic send_read(input slot_t slot, input offset_t offset);
    send_req(MODE_READ, 1'($urandom_range(1)), slot, offset);
  endtask

  // mostly reads of stored bytes, sometimes just past the end or anywhere
  task automatic random_read();
    slot_t slot;
    offset_t offset;
    int top;
    slot = slot_t'($urandom_range(bsmr_pkg::MSG_SLOTS - 1));
    offset = offset_t'($urandom_range(bsmr_pkg::MSG_BYTES - 1));
    if (sb.slots_used != 0 && $urandom_range(99) < 75) begin
      slot = slot_t'($urandom_range(sb.slots_used - 1));
      top = int'(sb.len_mem[slot]);
      offset = offset_t'((top != 0 && $urandom_range(3) != 0) ? $urandom_range(top - 1) : top);
    end
    send_read(slot, offset);
  endtask

  task automatic send_char(input logic [7:0] c);
    for (int i = 0; i < bsmr_pkg::CHAR_BITS; i++) begin
      if ($urandom_range(99) < 4) random_read();
      send_req(MODE_BIT, c[i], slot_t'($urandom_range(bsmr_pkg::MSG_SLOTS - 1)),
               offset_t'($urandom_range(bsmr_pkg::MSG_BYTES - 1)));
    end
  endtask

  task automatic send_msg(input byte_q_t chars);
    foreach (chars[i]) send_char(chars[i]);
    send_char(8'h00);
  endtask

  function automatic byte_q_t exit_msg();
    byte_q_t m;
    for (int i = 0; i < $size(bsmr_pkg::EXIT_WORD); i++) m.push_back(bsmr_pkg::EXIT_WORD[i]);
    return m;
  endfunction

  function automatic byte_q_t random_message();
    byte_q_t m;
    int kind;
    int n;
    kind = $urandom_range(99);
    if (kind < 12) begin
      m = exit_msg();
    end else if (kind < 22) begin
      // near misses of the exit word
      m = exit_msg();
      case ($urandom_range(2))
        0: m.pop_back();
        1: m.push_back(8'($urandom_range(1, 255)));
        default: m[$urandom_range(3)] ^= 8'h20;
      endcase
    end else begin
      n = (kind < 30) ? 0 : (kind < 85) ? $urandom_range(1, 6) : $urandom_range(7, 24);
      repeat (n) m.push_back(8'($urandom_range(1, 255)));
    end
    return m;
  endfunction

  task automatic random_action();
    int pick;
    pick = $urandom_range(99);
    if (pick < 20) begin
      random_read();
    end else if (pick < 25) begin
      // loose bits that shift the character framing
      repeat ($urandom_range(1, 7))
        send_req(MODE_BIT, 1'($urandom_range(1)),
                 slot_t'($urandom_range(bsmr_pkg::MSG_SLOTS - 1)),
                 offset_t'($urandom_range(bsmr_pkg::MSG_BYTES - 1)));
    end else begin
      send_msg(random_message());
    end
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (sb.due_count() != 0);
  endtask

  initial begin
    byte_q_t m;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // empty store, extreme read fields
    send_read('0, '0);
    send_read('1, '1);
    send_msg(m);
    send_msg(exit_msg());
    m = {8'hFF, 8'h01, 8'h80};
    send_msg(m);
    m = exit_msg();
    m.pop_back();
    send_msg(m);
    m = exit_msg();
    m.push_back(8'h73);
    send_msg(m);
    send_read(slot_t'(1), offset_t'(0));
    send_read(slot_t'(1), offset_t'(2));
    send_read(slot_t'(1), offset_t'(3));
    send_read(slot_t'(0), offset_t'(0));
    send_read(slot_t'(4), offset_t'(0));
    // exit again with the flag already set
    send_msg(exit_msg());

    while (items_sent < RANDOM_ITEMS) random_action();
    drain_results();

    // fill the remaining slots with empty messages, no idling on either side
    no_idle <= 1'b1;
    m.delete();
    while (sb.slots_used < bsmr_pkg::SLOTS_C) send_msg(m);
    no_idle <= 1'b0;

    // store full: message dropped, exit still recognized
    m = {8'h41, 8'h42};
    send_msg(m);
    send_msg(exit_msg());
    send_read('1, '0);
    send_read('1, sb.len_mem[bsmr_pkg::MSG_SLOTS - 1]);
    repeat (2) random_action();

    drain_results();
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.due_count() == 0) begin
      $display("bit_serial_message_receiver_top test passed");
    end else begin
      $display("bit_serial_message_receiver_top test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/bsmr_pkg.sv
rtl/bsmr_store.sv
rtl/bsmr_ctrl.sv
rtl/bit_serial_message_receiver_top.sv
bench/bit_serial_message_receiver_top_test.sv
